// ----- design/ctq_pkg.sv -----
// Shared types and codes for the coalescing two-priority command queue.
// No dependencies; ctq_ctrl and the top level import this package.
package ctq_pkg;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_SEND = 2'd1,
    MODE_POP  = 2'd2
  } mode_e_t;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_RETURNED = 3'd3,
    ST_REFUSED  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_P_RD,
    S_P_CMP,
    S_N_RD,
    S_N_CMP,
    S_PUSH,
    S_TAKE_RD,
    S_TAKE_CMP,
    S_DONE
  } state_t;

  // One result word as produced by the sequencer.
  typedef struct packed {
    status_t     status;
    logic [15:0] addr;
    logic [15:0] key;
    logic [15:0] data;
  } res_t;

endpackage

// ----- design/ctq_in_if.sv -----
// Command channel: valid/ready handshake with the command fields as payload.
// Depends on nothing.
interface ctq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic        prioritize;
  logic [15:0] device_address;
  logic [15:0] command_key;
  logic [15:0] command_data;

  modport source (output valid, mode, prioritize, device_address, command_key,
                  command_data, input ready);
  modport sink (input valid, mode, prioritize, device_address, command_key,
                command_data, output ready);
endinterface

// ----- design/ctq_out_if.sv -----
// Response channel: valid/ready handshake with status and returned item.
// Depends on nothing.
interface ctq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] item_address;
  logic [15:0] item_key;
  logic [15:0] item_data;

  modport source (output valid, status, item_address, item_key, item_data,
                  input ready);
  modport sink (input valid, status, item_address, item_key, item_data,
                output ready);
endinterface

// ----- design/ctq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ctq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ctq_ctrl.sv -----
// Sequencer of the command queue: FIFO pointers, pending slot, key search.
// Depends on ctq_pkg and ctq_in_if; drives the two FIFO RAMs.
module ctq_ctrl
  import ctq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH = 16,
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int DW = (DATA_WIDTH < 16) ? DATA_WIDTH : 16,
  localparam int EW = 32 + DW
) (
  input  logic          clk,
  input  logic          rst,
  ctq_in_if.sink        cmd_in,
  output logic          p_we,
  output logic [IW-1:0] p_waddr,
  output logic [EW-1:0] p_wdata,
  output logic [IW-1:0] p_raddr,
  input  logic [EW-1:0] p_rdata,
  output logic          n_we,
  output logic [IW-1:0] n_waddr,
  output logic [EW-1:0] n_wdata,
  output logic [IW-1:0] n_raddr,
  input  logic [EW-1:0] n_rdata,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res
);

  localparam int SW = CW + 1;

  state_t state, state_next;

  // Control state.
  logic [CW-1:0] cnt_p, cnt_n;
  logic [IW-1:0] head_p, head_n;
  logic          pend_valid;

  // Captured command and walk registers.
  logic [1:0]    mode_r;
  logic          prio_r;
  logic [15:0]   addr_r, key_r;
  logic [DW-1:0] data_r;
  logic [IW-1:0] pos;
  logic [CW-1:0] idx;
  logic          sel_p;
  logic [15:0]   pend_addr, pend_key;
  logic [DW-1:0] pend_data;

  logic          in_fire;
  logic [15:0]   rd_p_addr, rd_p_key, rd_n_addr, rd_n_key;
  logic [15:0]   tk_addr, tk_key;
  logic [DW-1:0] tk_data;
  logic          hit_p, hit_n, last_p, last_n;
  logic [IW-1:0] tgt_head, tail;
  logic [CW-1:0] tgt_cnt;
  logic [SW-1:0] tail_sum;
  logic          tgt_full;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    wrap_inc = (p == IW'(QUEUE_DEPTH - 1)) ? '0 : IW'(p + 1'b1);
  endfunction

  assign in_fire = cmd_in.valid && cmd_in.ready;

  assign rd_p_addr = p_rdata[EW-1 -: 16];
  assign rd_p_key  = p_rdata[DW +: 16];
  assign rd_n_addr = n_rdata[EW-1 -: 16];
  assign rd_n_key  = n_rdata[DW +: 16];
  assign hit_p     = (rd_p_key == key_r);
  assign hit_n     = (rd_n_key == key_r);
  assign last_p    = (CW'(idx + 1'b1) == cnt_p);
  assign last_n    = (CW'(idx + 1'b1) == cnt_n);

  assign tk_addr = sel_p ? rd_p_addr : rd_n_addr;
  assign tk_key  = sel_p ? rd_p_key : rd_n_key;
  assign tk_data = sel_p ? p_rdata[DW-1:0] : n_rdata[DW-1:0];

  // Tail of the FIFO that a new command goes to; head + count wraps once at most.
  assign tgt_head = prio_r ? head_p : head_n;
  assign tgt_cnt  = prio_r ? cnt_p : cnt_n;
  assign tgt_full = (tgt_cnt == CW'(QUEUE_DEPTH));
  assign tail_sum = SW'(tgt_head) + SW'(tgt_cnt);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? IW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : IW'(tail_sum);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (mode_r)
          MODE_ADD: begin
            if (cnt_p != '0) state_next = S_P_RD;
            else if (cnt_n != '0) state_next = S_N_RD;
            else state_next = S_PUSH;
          end
          MODE_SEND: begin
            if (!pend_valid && (cnt_p != '0 || cnt_n != '0)) state_next = S_TAKE_RD;
            else state_next = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_P_RD:  state_next = S_P_CMP;
      S_P_CMP: begin
        if (hit_p) state_next = S_DONE;
        else if (last_p) state_next = (cnt_n != '0) ? S_N_RD : S_PUSH;
        else state_next = S_P_RD;
      end
      S_N_RD:  state_next = S_N_CMP;
      S_N_CMP: begin
        if (hit_n) state_next = S_DONE;
        else if (last_n) state_next = S_PUSH;
        else state_next = S_N_RD;
      end
      S_PUSH:     state_next = S_DONE;
      S_TAKE_RD:  state_next = S_TAKE_CMP;
      S_TAKE_CMP: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_in.ready = (state == S_IDLE);
    res_valid    = (state == S_DONE);
    p_raddr      = pos;
    n_raddr      = pos;
    p_we         = (state == S_P_CMP && hit_p) || (state == S_PUSH && prio_r && !tgt_full);
    n_we         = (state == S_N_CMP && hit_n) || (state == S_PUSH && !prio_r && !tgt_full);
    p_waddr      = (state == S_PUSH) ? tail : pos;
    n_waddr      = (state == S_PUSH) ? tail : pos;
    p_wdata      = (state == S_PUSH) ? {addr_r, key_r, data_r} : {rd_p_addr, key_r, data_r};
    n_wdata      = (state == S_PUSH) ? {addr_r, key_r, data_r} : {rd_n_addr, key_r, data_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt_p      <= '0;
      cnt_n      <= '0;
      head_p     <= '0;
      head_n     <= '0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_EXEC: begin
          if (mode_r == MODE_POP && pend_valid && pend_addr == addr_r) pend_valid <= 1'b0;
        end
        S_PUSH: begin
          if (!tgt_full) begin
            if (prio_r) cnt_p <= CW'(cnt_p + 1'b1);
            else cnt_n <= CW'(cnt_n + 1'b1);
          end
        end
        S_TAKE_CMP: begin
          if (tk_addr == addr_r) begin
            pend_valid <= 1'b1;
            if (sel_p) begin
              head_p <= wrap_inc(head_p);
              cnt_p  <= CW'(cnt_p - 1'b1);
            end else begin
              head_n <= wrap_inc(head_n);
              cnt_n  <= CW'(cnt_n - 1'b1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers; only read in states where they have been loaded.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= cmd_in.mode;
      prio_r <= cmd_in.prioritize;
      addr_r <= cmd_in.device_address;
      key_r  <= cmd_in.command_key;
      data_r <= cmd_in.command_data[DW-1:0];
    end
    case (state)
      S_EXEC: begin
        idx   <= '0;
        sel_p <= (cnt_p != '0);
        pos   <= (cnt_p != '0) ? head_p : head_n;
        res   <= '{status: ST_REFUSED, addr: '0, key: '0, data: '0};
        if (mode_r == MODE_SEND && pend_valid && pend_addr == addr_r) begin
          res <= '{status: ST_RETURNED, addr: pend_addr, key: pend_key, data: 16'(pend_data)};
        end
        if (mode_r == MODE_POP && pend_valid && pend_addr == addr_r) begin
          res <= '{status: ST_RETURNED, addr: pend_addr, key: pend_key, data: 16'(pend_data)};
        end
      end
      S_P_CMP: begin
        if (hit_p) begin
          res <= '{status: ST_UPDATED, addr: '0, key: '0, data: '0};
        end else if (last_p) begin
          pos <= head_n;
          idx <= '0;
        end else begin
          pos <= wrap_inc(pos);
          idx <= CW'(idx + 1'b1);
        end
      end
      S_N_CMP: begin
        if (hit_n) begin
          res <= '{status: ST_UPDATED, addr: '0, key: '0, data: '0};
        end else begin
          pos <= wrap_inc(pos);
          idx <= CW'(idx + 1'b1);
        end
      end
      S_PUSH: begin
        res <= '{status: tgt_full ? ST_DROPPED : ST_APPENDED, addr: '0, key: '0, data: '0};
      end
      S_TAKE_CMP: begin
        if (tk_addr == addr_r) begin
          pend_addr <= tk_addr;
          pend_key  <= tk_key;
          pend_data <= tk_data;
          res <= '{status: ST_RETURNED, addr: tk_addr, key: tk_key, data: 16'(tk_data)};
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- design/coalescing_two_priority_command_queue_unit.sv -----
// Top level of the coalescing two-priority command queue.
// Depends on ctq_pkg, ctq_in_if, ctq_out_if, ctq_ram and ctq_ctrl.
//
//  Channel   Role    Word carried
//  cmd_in    sink    mode, prioritize, device_address, command_key, command_data
//  rsp_out   source  status, item_address, item_key, item_data
//
// Every accepted command word yields exactly one response word. The sequencer
// handles one command at a time; the key search of an add reads one FIFO entry
// at a time from the FIFO RAMs, priority FIFO first, in a read state and then a
// compare state per entry. An add that finds no matching key ends in a push
// step that appends the command or drops it when its FIFO is full. A send reads
// a FIFO head only when no item is pending and a FIFO holds an entry; a pop only checks the pending slot.
// Reset (rst, synchronous) empties both FIFOs and the pending slot at once.
// The response goes through an output register, so a stalled rsp_out does not
// stop the next command from being accepted; only its result then waits.
module coalescing_two_priority_command_queue_unit
  import ctq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  ctq_in_if.sink    cmd_in,
  ctq_out_if.source rsp_out
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int DW = (DATA_WIDTH < 16) ? DATA_WIDTH : 16;
  localparam int EW = 32 + DW;

  // RAM ports of the priority FIFO (p_) and the normal FIFO (n_).
  logic          p_we, n_we;
  logic [IW-1:0] p_waddr, p_raddr, n_waddr, n_raddr;
  logic [EW-1:0] p_wdata, p_rdata, n_wdata, n_rdata;

  logic res_valid, res_ready;
  res_t res;

  // Output register.
  logic out_valid;
  res_t out_word;

  ctq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  ctq_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_norm_ram (
    .clk   (clk),
    .we    (n_we),
    .waddr (n_waddr),
    .wdata (n_wdata),
    .raddr (n_raddr),
    .rdata (n_rdata)
  );

  ctq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd_in),
    .p_we      (p_we),
    .p_waddr   (p_waddr),
    .p_wdata   (p_wdata),
    .p_raddr   (p_raddr),
    .p_rdata   (p_rdata),
    .n_we      (n_we),
    .n_waddr   (n_waddr),
    .n_wdata   (n_wdata),
    .n_raddr   (n_raddr),
    .n_rdata   (n_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The sequencer may hand over a new result whenever the register is empty
  // or its current word leaves in this cycle.
  assign res_ready = !out_valid || rsp_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign rsp_out.valid        = out_valid;
  assign rsp_out.status       = out_word.status;
  assign rsp_out.item_address = out_word.addr;
  assign rsp_out.item_key     = out_word.key;
  assign rsp_out.item_data    = out_word.data;

`ifndef SYNTHESIS
  // The sequencer works on one command at a time.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_in.valid && cmd_in.ready) |=> !cmd_in.ready)
    else $error("command accepted while another is in progress");

  // Item fields are zero unless an item is returned.
  assert property (@(posedge clk) disable iff (rst)
    (rsp_out.valid && rsp_out.status != ST_RETURNED) |->
      (rsp_out.item_address == '0 && rsp_out.item_key == '0 && rsp_out.item_data == '0))
    else $error("item fields set on a response without an item");

  // A new response appears only when the sequencer finishes a command.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_out.valid) |-> $past(!cmd_in.ready))
    else $error("response produced while the sequencer was idle");
`endif

endmodule
